// File: src/fltw_pkg.sv
`default_nettype none

package fltw_pkg;

   // Store geometry
   localparam int TABLE_COUNT       = 8;
   localparam int LEVELS            = 4;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int INDEX_W           = 9;
   localparam int PAGE_SHIFT        = 12;
   localparam int STORE_DEPTH       = TABLE_COUNT * ENTRIES_PER_TABLE;
   localparam int FRAME_W           = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int ADDR_W            = FRAME_W + INDEX_W;
   localparam int WIDE_W            = 16;
   localparam int ENTRY_W           = 64;
   localparam int VA_W              = 48;
   localparam int FIELD_W           = 40;
   localparam int FRAME_ADDR_W      = 52;
   localparam int ROOT_W            = 3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [2:0] level_type;

   localparam level_type LEVEL_LAST = 3'd1;
   localparam level_type LEVEL_TOP  = 3'(LEVELS);
   localparam logic [FIELD_W-1:0] FRAME_LIMIT = FIELD_W'(TABLE_COUNT);
   localparam logic [WIDE_W-1:0]  INDEX_LIMIT = WIDE_W'(STORE_DEPTH);

   // Command codes
   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOT_PRESENT = 2'd1,
      ST_OUTSIDE     = 2'd2
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_WALK
   } back_state_type;

   typedef struct packed {
      logic                cmd;
      logic [VA_W-1:0]     virtual_address;
      logic [2:0]          stop_level;
      logic [11:0]         store_index;
      logic [ENTRY_W-1:0]  store_data;
   } req_type;

   typedef struct packed {
      status_type              status;
      level_type               fault_level;
      logic [ENTRY_W-1:0]      entry_value;
      logic [FRAME_ADDR_W-1:0] frame_address;
   } rsp_type;

   // Classified transaction handed from front to back
   typedef struct packed {
      logic                is_write;
      logic                write_ok;
      logic [ADDR_W-1:0]   write_addr;
      logic [ENTRY_W-1:0]  write_data;
      logic                root_fault;
      logic [FRAME_W-1:0]  root_frame;
      level_type           stop_level;
      logic [VA_W-1:0]     virtual_address;
   } cmd_type;

   // Pick the 9-bit table index of one level out of the virtual address
   function automatic logic [INDEX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                      input level_type level);
      logic [INDEX_W-1:0] idx;
      case (level)
         3'd1:    idx = va[20:12];
         3'd2:    idx = va[29:21];
         3'd3:    idx = va[38:30];
         default: idx = va[47:39];
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: src/fltw_ram.sv
`default_nettype none

module fltw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: src/fltw_front.sv
`default_nettype none

module fltw_front
   import fltw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              queue_full,
   input  wire req_type           req_data,
   input  wire logic              csr_we,
   input  wire logic [ROOT_W-1:0] csr_wdata,
   output logic                   push,
   output cmd_type                push_cmd
);

   logic [ROOT_W-1:0] root_frame_ff;
   logic [ROOT_W-1:0] root_frame_in;
   logic [WIDE_W-1:0] index_wide;
   level_type         stop_clamped;

   // Hold the root frame register
   always_comb begin
      root_frame_in = csr_we ? csr_wdata : root_frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
      end else begin
         root_frame_ff <= root_frame_in;
      end
   end

   // Clamp the stop level into 1..4
   always_comb begin
      if (req_data.stop_level < LEVEL_LAST) begin
         stop_clamped = LEVEL_LAST;
      end else if (req_data.stop_level > LEVEL_TOP) begin
         stop_clamped = LEVEL_TOP;
      end else begin
         stop_clamped = req_data.stop_level;
      end
   end

   // Classify the incoming transaction
   always_comb begin
      index_wide               = WIDE_W'(req_data.store_index);
      push                     = start && !queue_full;
      push_cmd.is_write        = (req_data.cmd == CMD_WRITE);
      push_cmd.write_ok        = (index_wide < INDEX_LIMIT);
      push_cmd.write_addr      = index_wide[ADDR_W-1:0];
      push_cmd.write_data      = req_data.store_data;
      push_cmd.root_fault      = (FIELD_W'(root_frame_ff) >= FRAME_LIMIT);
      push_cmd.root_frame      = FRAME_W'(root_frame_ff);
      push_cmd.stop_level      = stop_clamped;
      push_cmd.virtual_address = req_data.virtual_address;
   end

endmodule

`default_nettype wire

// File: src/fltw_queue.sv
`default_nettype none

module fltw_queue
   import fltw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   // Advance pointers and count
   always_comb begin
      full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: src/fltw_back.sv
`default_nettype none

module fltw_back
   import fltw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire cmd_type head_cmd,
   output logic         pop,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   back_state_type     state_ff;
   back_state_type     state_in;
   cmd_type            cur_ff;
   cmd_type            cur_in;
   level_type          level_ff;
   level_type          level_in;
   logic               rsp_strobe_ff;
   logic               rsp_strobe_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [FIELD_W-1:0] next_frame;
   logic               walk_next;

   fltw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Hold state, level and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      level_ff <= level_in;
      rsp_ff   <= rsp_in;
   end

   // Sequence writes and table walks
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      level_in      = level_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = head_cmd.write_addr;
      ram_wdata     = head_cmd.write_data;
      ram_raddr     = {head_cmd.root_frame,
                       level_index(head_cmd.virtual_address, LEVEL_TOP)};
      next_frame    = ram_rdata[PAGE_SHIFT +: FIELD_W];
      walk_next     = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head_cmd;
               rsp_in = '{status: ST_OK, fault_level: '0, entry_value: '0,
                          frame_address: '0};
               if (head_cmd.is_write) begin
                  ram_we        = head_cmd.write_ok;
                  rsp_strobe_in = 1'b1;
               end else if (head_cmd.root_fault) begin
                  rsp_in.status      = ST_OUTSIDE;
                  rsp_in.fault_level = LEVEL_TOP;
                  rsp_strobe_in      = 1'b1;
               end else begin
                  level_in = LEVEL_TOP;
                  state_in = BK_WALK;
               end
            end
         end
         BK_WALK: begin
            ram_raddr = {FRAME_W'(next_frame),
                         level_index(cur_ff.virtual_address, level_ff - 3'd1)};
            rsp_in    = '{status: ST_OK, fault_level: '0, entry_value: '0,
                          frame_address: '0};
            if (level_ff == cur_ff.stop_level) begin
               rsp_in.entry_value   = ram_rdata;
               rsp_in.frame_address = {next_frame, {PAGE_SHIFT{1'b0}}};
               rsp_strobe_in        = 1'b1;
               state_in             = BK_IDLE;
            end else if (!ram_rdata[0]) begin
               rsp_in.status      = ST_NOT_PRESENT;
               rsp_in.fault_level = level_ff;
               rsp_strobe_in      = 1'b1;
               state_in           = BK_IDLE;
            end else if (next_frame >= FRAME_LIMIT) begin
               rsp_in.status      = ST_OUTSIDE;
               rsp_in.fault_level = level_ff;
               rsp_strobe_in      = 1'b1;
               state_in           = BK_IDLE;
            end else begin
               walk_next = 1'b1;
               level_in  = level_ff - 3'd1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_strobe = rsp_strobe_ff;
      rsp_data   = rsp_ff;
   end

   // Walk never passes below the stop level
   assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_WALK |-> level_ff >= cur_ff.stop_level)
      else $error("walk level below stop level");

   // Take a new transaction only between walks
   assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == BK_IDLE)
      else $error("queue popped during a walk");

   // Descend exactly one level per table read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WALK && walk_next) |=>
         (state_ff == BK_WALK && level_ff == $past(level_ff) - 3'd1))
      else $error("walk did not descend one level");

   // Drop entry data on any fault
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status != ST_OK) |->
         (rsp_ff.entry_value == '0 && rsp_ff.frame_address == '0
          && rsp_ff.fault_level != '0))
      else $error("fault response carries entry data");

   // A walk that finishes returns to idle with one response
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WALK && !walk_next) |=> (state_ff == BK_IDLE && rsp_strobe_ff))
      else $error("walk ended without a response");

endmodule

`default_nettype wire

// File: src/four_level_page_table_walker.sv
// A write passes the queue slot, then the registered response; a translate also reads
// one dependent table entry per level, from level 4 down to stop_level, then responds.
// Throughput: one write per cycle while no walk is running; walks do not overlap, and
// the table store has a single read port. A 2-deep queue decouples intake.
// The receiver cannot stall: each response is shown for one cycle on rsp_strobe.
// Reset (synchronous) empties the queue, idles the walker and clears root_frame.
`default_nettype none

module four_level_page_table_walker
   import fltw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire logic [ROOT_W-1:0] csr_wdata
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   fltw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .queue_full (queue_full),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   fltw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   fltw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Hold off new transactions while the queue is full
   assign busy = queue_full;

endmodule

`default_nettype wire
